// ===== hw/rtl/rpwc_pkg.sv =====
package rpwc_pkg;

    // fixed field widths
    localparam int SLOTS          = 6;
    localparam int WIDTH_BITS     = 16;
    localparam int CFG_ADDR_BITS  = 2;
    localparam int CFG_DATA_BITS  = 16;

    // parameter defaults
    localparam int NUM_CHANNELS_DEF = 6;
    localparam int COUNT_BITS_DEF   = 16;

    // register indexes
    localparam logic [CFG_ADDR_BITS-1:0] REG_CLAMP_LOW      = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_CLAMP_HIGH     = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_CHANNEL_ENABLE = 2'd2;

    // register reset values
    localparam logic [WIDTH_BITS-1:0] CLAMP_LOW_RST      = 16'd100;
    localparam logic [WIDTH_BITS-1:0] CLAMP_HIGH_RST     = 16'd200;
    localparam logic [SLOTS-1:0]      CHANNEL_ENABLE_RST = 6'd7;

    typedef struct packed {
        logic [WIDTH_BITS-1:0] low;
        logic [WIDTH_BITS-1:0] high;
    } clamp_t;

    typedef struct packed {
        logic [WIDTH_BITS-1:0] width;
        logic                  fresh;
    } chan_result_t;

endpackage

// ===== hw/rtl/rpwc_ifs.sv =====
interface rpwc_in_if;
    logic                     valid;
    logic                     ready;
    logic [rpwc_pkg::SLOTS-1:0] pin_levels;

    modport source (output valid, output pin_levels, input ready);
    modport sink   (input valid, input pin_levels, output ready);
endinterface

interface rpwc_out_if;
    logic                          valid;
    logic                          ready;
    logic [rpwc_pkg::WIDTH_BITS-1:0] width_one;
    logic [rpwc_pkg::WIDTH_BITS-1:0] width_two;
    logic [rpwc_pkg::WIDTH_BITS-1:0] width_three;
    logic [rpwc_pkg::WIDTH_BITS-1:0] width_four;
    logic [rpwc_pkg::WIDTH_BITS-1:0] width_five;
    logic [rpwc_pkg::WIDTH_BITS-1:0] width_six;
    logic [rpwc_pkg::SLOTS-1:0]      fresh_mask;

    modport source (output valid, output width_one, output width_two, output width_three,
                    output width_four, output width_five, output width_six,
                    output fresh_mask, input ready);
    modport sink   (input valid, input width_one, input width_two, input width_three,
                    input width_four, input width_five, input width_six,
                    input fresh_mask, output ready);
endinterface

interface rpwc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [rpwc_pkg::CFG_ADDR_BITS-1:0] addr;
    logic [rpwc_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

// ===== hw/rtl/rpwc_channel.sv =====
module rpwc_channel #(
    parameter int COUNT_BITS = rpwc_pkg::COUNT_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic                   level,
    input  logic                   enabled,
    input  rpwc_pkg::clamp_t       clamp,
    output rpwc_pkg::chan_result_t result
);
    import rpwc_pkg::*;

    localparam int CMP_BITS = (COUNT_BITS > WIDTH_BITS) ? COUNT_BITS : WIDTH_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic                  prev_level_reg;
    logic                  measuring_reg;
    logic                  measuring_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [COUNT_BITS-1:0] latched_reg;
    logic [COUNT_BITS-1:0] latched_next;
    logic                  fresh;
    logic [CMP_BITS-1:0]   width_ext;

    always_comb
    begin
        measuring_next = measuring_reg;
        count_next     = count_reg;
        latched_next   = latched_reg;
        fresh          = 1'b0;
        if (!enabled)
        begin
            measuring_next = 1'b0;
        end
        else if (level && !prev_level_reg)
        begin
            measuring_next = 1'b1;
            count_next     = COUNT_BITS'(1);
        end
        else if (level && measuring_reg)
        begin
            if (count_reg != COUNT_MAX)
            begin
                count_next = count_reg + COUNT_BITS'(1);
            end
        end
        else if (!level && prev_level_reg && measuring_reg)
        begin
            latched_next   = count_reg;
            measuring_next = 1'b0;
            fresh          = 1'b1;
        end
    end

    // low limit first, then high limit wins
    always_comb
    begin
        width_ext = CMP_BITS'(latched_next);
        if (width_ext < CMP_BITS'(clamp.low))
        begin
            width_ext = CMP_BITS'(clamp.low);
        end
        if (width_ext > CMP_BITS'(clamp.high))
        begin
            width_ext = CMP_BITS'(clamp.high);
        end
        result.width = width_ext[WIDTH_BITS-1:0];
        result.fresh = fresh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= 1'b1;
            measuring_reg  <= 1'b0;
            count_reg      <= '0;
            latched_reg    <= '0;
        end
        else if (advance)
        begin
            prev_level_reg <= level;
            measuring_reg  <= measuring_next;
            count_reg      <= count_next;
            latched_reg    <= latched_next;
        end
    end

endmodule

// ===== hw/rtl/rc_pulse_width_capture.sv =====
// result: each accepted tick word's result word is registered and valid in the next cycle
// throughput: one tick word per cycle, limited only by the output register draining
// reset: rst_n clears the output valid flag, resets all channel state and loads the
//        default limits (100/200) and channel enable (channels 1..3)
module rc_pulse_width_capture #(
    parameter int NUM_CHANNELS = rpwc_pkg::NUM_CHANNELS_DEF,
    parameter int COUNT_BITS   = rpwc_pkg::COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    rpwc_in_if.sink     in_ch,
    rpwc_out_if.source  out_ch,
    rpwc_cfg_if.sink    cfg
);
    import rpwc_pkg::*;

    // configuration registers; the user must write them only while idle, the block does not enforce it
    logic [WIDTH_BITS-1:0] clamp_low_reg;
    logic [WIDTH_BITS-1:0] clamp_high_reg;
    logic [SLOTS-1:0]      enable_reg;
    clamp_t                clamp;

    // output register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [WIDTH_BITS-1:0] width_reg [SLOTS];
    logic [SLOTS-1:0]      fresh_reg;

    logic                  advance;
    chan_result_t          results [SLOTS];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clamp_low_reg  <= CLAMP_LOW_RST;
            clamp_high_reg <= CLAMP_HIGH_RST;
            enable_reg     <= CHANNEL_ENABLE_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                REG_CLAMP_LOW:      clamp_low_reg  <= cfg.data;
                REG_CLAMP_HIGH:     clamp_high_reg <= cfg.data;
                REG_CHANNEL_ENABLE: enable_reg     <= cfg.data[SLOTS-1:0];
                default:            ;
            endcase
        end
    end

    assign clamp.low  = clamp_low_reg;
    assign clamp.high = clamp_high_reg;

    // take a new tick whenever the output register is empty or draining
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign advance     = in_ch.valid && in_ch.ready;

    // one channel unit per implemented channel; unused slots read zero
    for (genvar k = 0; k < SLOTS; k++)
    begin : g_slot
        if (k < NUM_CHANNELS)
        begin : g_chan
            rpwc_channel #(
                .COUNT_BITS (COUNT_BITS)
            ) u_chan (
                .clk     (clk),
                .rst_n   (rst_n),
                .advance (advance),
                .level   (in_ch.pin_levels[k]),
                .enabled (enable_reg[k]),
                .clamp   (clamp),
                .result  (results[k])
            );
        end
        else
        begin : g_unused
            assign results[k] = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded with the tick that produced it
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                width_reg[k] <= results[k].width;
                fresh_reg[k] <= results[k].fresh;
            end
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.width_one   = width_reg[0];
    assign out_ch.width_two   = width_reg[1];
    assign out_ch.width_three = width_reg[2];
    assign out_ch.width_four  = width_reg[3];
    assign out_ch.width_five  = width_reg[4];
    assign out_ch.width_six   = width_reg[5];
    assign out_ch.fresh_mask  = fresh_reg;

endmodule

// ===== hw/rtl/rpwc_checker.sv =====
module rpwc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic [rpwc_pkg::SLOTS-1:0]       pin_levels,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [rpwc_pkg::WIDTH_BITS-1:0]  width_one,
    input logic [rpwc_pkg::SLOTS-1:0]       fresh_mask
);
    import rpwc_pkg::*;

    // an accepted tick always yields a result word next cycle
    a_accept_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted tick gave no result word");

    // a full, stalled output register blocks new ticks
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("tick accepted while result word stalled");

    // a latch happens on a falling edge, so the pin was low in that tick
    a_fresh_on_low_pin: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> (fresh_mask & $past(pin_levels)) == '0)
        else $error("fresh channel whose pin was high");

    // a result word only appears after an accepted tick
    a_no_invented_word: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result word without a tick");

    // stalled result word holds
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(width_one) && $stable(fresh_mask))
        else $error("stalled result word changed");

endmodule

bind rc_pulse_width_capture rpwc_checker u_rpwc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .pin_levels (in_ch.pin_levels),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .width_one  (out_ch.width_one),
    .fresh_mask (out_ch.fresh_mask)
);
